[rtl/core/qcs_pkg.sv]
// ----------------------------------------------------------------------------
// qcs_pkg
// Types, widths and constants shared by the quadrature counter blocks.
// ----------------------------------------------------------------------------
`default_nettype none

package qcs_pkg;

   // field widths
   localparam int unsigned DELTA_W   = 16;
   localparam int unsigned TOTAL_W   = 32;
   localparam int unsigned SPEED_W   = 32;
   localparam int unsigned ELAPSED_W = 16;
   localparam int unsigned CPR_W     = 16;

   // speed datapath widths
   localparam int unsigned SCALE_W = 20;
   localparam int unsigned DEN_W   = 32;
   localparam int unsigned NUM_W   = 35;
   localparam int unsigned QUOT_W  = NUM_W;
   localparam int unsigned CNT_W   = 6;

   // tenths of rpm per count per millisecond per rev
   localparam logic [SCALE_W-1:0] SPEED_SCALE = 20'd600000;
   localparam logic [CPR_W-1:0]   CPR_RESET   = 16'd1024;

   // saturation limits
   localparam logic signed [DELTA_W-1:0] DELTA_MAX = 16'sh7FFF;
   localparam logic signed [DELTA_W-1:0] DELTA_MIN = 16'sh8000;
   localparam logic [SPEED_W-1:0]        SPEED_MAX = 32'h7FFF_FFFF;
   localparam logic [QUOT_W-1:0]         QUOT_POS_LIM = 35'h7FFF_FFFF;
   localparam logic [QUOT_W-1:0]         QUOT_NEG_LIM = 35'h8000_0000;

   // decoded step codes
   localparam logic signed [1:0] STEP_NONE = 2'sb00;
   localparam logic signed [1:0] STEP_UP   = 2'sb01;
   localparam logic signed [1:0] STEP_DOWN = 2'sb11;

   // item passed from the front to the back through the queue
   typedef struct packed {
      logic                        delta_valid;
      logic signed [DELTA_W-1:0]   delta;
      logic signed [TOTAL_W-1:0]   total;
      logic [ELAPSED_W-1:0]        window_ms;
   } qcs_item_type;

   // queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } qcs_fifo_status_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MUL,
      BK_NUM,
      BK_DIV,
      BK_DONE
   } qcs_back_state_type;

   // x4 transition table, index is {prev_a, prev_b, cur_a, cur_b}
   function automatic logic signed [1:0] step_of(input logic [3:0] idx);
      logic signed [1:0] step;
      case (idx)
         4'h1, 4'h7, 4'h8, 4'hE: step = STEP_DOWN;
         4'h2, 4'h4, 4'hB, 4'hD: step = STEP_UP;
         default:                step = STEP_NONE;
      endcase
      return step;
   endfunction

endpackage

`default_nettype wire

[rtl/core/qcs_front.sv]
// ----------------------------------------------------------------------------
// qcs_front
// Decodes pin transitions, keeps pending and total counts, builds queue items.
// ----------------------------------------------------------------------------
`default_nettype none

module qcs_front (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           accept,
   input  wire logic                           pin_a,
   input  wire logic                           pin_b,
   input  wire logic                           clear,
   input  wire logic                           take_delta,
   input  wire logic [qcs_pkg::ELAPSED_W-1:0]  window_ms,
   output qcs_pkg::qcs_item_type               item
);
   import qcs_pkg::*;

   logic [1:0]                prev_ff, prev_in;
   logic signed [TOTAL_W-1:0] pending_ff, pending_in;
   logic signed [TOTAL_W-1:0] total_ff, total_in;
   logic [1:0]                cur;
   logic signed [1:0]         step;
   logic signed [TOTAL_W-1:0] step_ext;
   logic signed [TOTAL_W-1:0] pend_sum;
   logic signed [DELTA_W-1:0] delta_sat;

   // decode and count
   always_comb begin
      cur      = {pin_a, pin_b};
      step     = step_of({prev_ff, cur});
      step_ext = {{(TOTAL_W-2){step[1]}}, step};
      prev_in  = cur;
      if (clear) begin
         pend_sum = '0;
         total_in = '0;
      end else begin
         pend_sum = pending_ff + step_ext;
         total_in = total_ff + step_ext;
      end
      // saturate pending count to the delta width
      if (!pend_sum[TOTAL_W-1] && (|pend_sum[TOTAL_W-2:DELTA_W-1])) begin
         delta_sat = DELTA_MAX;
      end else if (pend_sum[TOTAL_W-1] && !(&pend_sum[TOTAL_W-2:DELTA_W-1])) begin
         delta_sat = DELTA_MIN;
      end else begin
         delta_sat = pend_sum[DELTA_W-1:0];
      end
      pending_in = take_delta ? '0 : pend_sum;
      item.delta_valid = take_delta;
      item.delta       = take_delta ? delta_sat : '0;
      item.total       = total_in;
      item.window_ms   = window_ms;
   end

   // count state
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff    <= '0;
         pending_ff <= '0;
         total_ff   <= '0;
      end else if (accept) begin
         prev_ff    <= prev_in;
         pending_ff <= pending_in;
         total_ff   <= total_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/qcs_fifo.sv]
// ----------------------------------------------------------------------------
// qcs_fifo
// Short item queue between the decode front and the speed back.
// ----------------------------------------------------------------------------
`default_nettype none

module qcs_fifo #(
   parameter int unsigned DEPTH = 2
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   wr_en,
   input  wire qcs_pkg::qcs_item_type  wr_item,
   input  wire logic                   rd_en,
   output qcs_pkg::qcs_item_type       rd_item,
   output qcs_pkg::qcs_fifo_status_type status
);
   import qcs_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W_Q = $clog2(DEPTH + 1);

   qcs_item_type         slot_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W_Q-1:0]   count_ff, count_in;
   logic                 do_wr, do_rd;

   // pointer and fill count update
   always_comb begin
      status.full  = (count_ff == CNT_W_Q'(DEPTH));
      status.empty = (count_ff == '0);
      do_wr = wr_en && !status.full;
      do_rd = rd_en && !status.empty;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
      rd_item = slot_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

`default_nettype wire

[rtl/core/qcs_back.sv]
// ----------------------------------------------------------------------------
// qcs_back
// Speed computation: scale, restoring divide, rounding, saturation, result reg.
// ----------------------------------------------------------------------------
`default_nettype none

module qcs_back (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic [qcs_pkg::CPR_W-1:0]        counts_per_rev,
   input  wire qcs_pkg::qcs_fifo_status_type     fifo_status,
   input  wire qcs_pkg::qcs_item_type            head_item,
   output logic                                  fifo_pop,
   output logic                                  rsp_empty,
   input  wire logic                             rsp_pop,
   output logic                                  rsp_delta_valid,
   output logic signed [qcs_pkg::DELTA_W-1:0]    rsp_delta,
   output logic signed [qcs_pkg::TOTAL_W-1:0]    rsp_total,
   output logic signed [qcs_pkg::SPEED_W-1:0]    rsp_speed_rpm_x10
);
   import qcs_pkg::*;

   qcs_back_state_type        state_ff, state_in;
   qcs_item_type              item_ff, item_in;
   logic                      neg_ff, neg_in;
   logic [DELTA_W-1:0]        mag_ff, mag_in;
   logic [DEN_W-1:0]          den_ff, den_in;
   logic [NUM_W-1:0]          num_ff, num_in;
   logic [DEN_W-1:0]          rem_ff, rem_in;
   logic [QUOT_W-1:0]         quot_ff, quot_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic                      out_valid_ff, out_valid_in;
   logic                      out_dv_ff, out_dv_in;
   logic signed [DELTA_W-1:0] out_delta_ff, out_delta_in;
   logic signed [TOTAL_W-1:0] out_total_ff, out_total_in;
   logic [SPEED_W-1:0]        out_speed_ff, out_speed_in;
   logic [DEN_W:0]            rem_sh;
   logic                      rem_ge;
   logic [QUOT_W-1:0]         quot_lim;
   logic [SPEED_W-1:0]        speed;

   // saturate and sign the quotient
   always_comb begin
      if (neg_ff) begin
         quot_lim = (quot_ff > QUOT_NEG_LIM) ? QUOT_NEG_LIM : quot_ff;
         speed    = '0 - quot_lim[SPEED_W-1:0];
      end else begin
         quot_lim = quot_ff;
         speed    = (quot_ff > QUOT_POS_LIM) ? SPEED_MAX : quot_ff[SPEED_W-1:0];
      end
   end

   // one restoring divide step
   always_comb begin
      rem_sh = {rem_ff, num_ff[NUM_W-1]};
      rem_ge = (rem_sh >= {1'b0, den_ff});
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      den_in       = den_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      quot_in      = quot_ff;
      cnt_in       = cnt_ff;
      out_dv_in    = out_dv_ff;
      out_delta_in = out_delta_ff;
      out_total_in = out_total_ff;
      out_speed_in = out_speed_ff;
      fifo_pop     = 1'b0;
      out_valid_in = out_valid_ff && !rsp_pop;
      case (state_ff)
         BK_IDLE: begin
            if (!fifo_status.empty) begin
               fifo_pop = 1'b1;
               item_in  = head_item;
               neg_in   = head_item.delta[DELTA_W-1];
               mag_in   = neg_in ? (DELTA_W'(0) - head_item.delta) : head_item.delta;
               quot_in  = '0;
               if (!head_item.delta_valid || (head_item.window_ms == '0)
                   || (counts_per_rev == '0)) begin
                  state_in = BK_DONE;
               end else begin
                  state_in = BK_MUL;
               end
            end
         end
         BK_MUL: begin
            den_in   = DEN_W'(counts_per_rev) * DEN_W'(item_ff.window_ms);
            state_in = BK_NUM;
         end
         BK_NUM: begin
            num_in   = NUM_W'(mag_ff) * NUM_W'(SPEED_SCALE) + NUM_W'(den_ff >> 1);
            rem_in   = '0;
            quot_in  = '0;
            cnt_in   = '0;
            state_in = BK_DIV;
         end
         BK_DIV: begin
            rem_in  = rem_ge ? DEN_W'(rem_sh - {1'b0, den_ff}) : rem_sh[DEN_W-1:0];
            quot_in = {quot_ff[QUOT_W-2:0], rem_ge};
            num_in  = {num_ff[NUM_W-2:0], 1'b0};
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(QUOT_W - 1)) begin
               state_in = BK_DONE;
            end
         end
         BK_DONE: begin
            if (!out_valid_ff || rsp_pop) begin
               out_valid_in = 1'b1;
               out_dv_in    = item_ff.delta_valid;
               out_delta_in = item_ff.delta;
               out_total_in = item_ff.total;
               out_speed_in = speed;
               state_in     = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      neg_ff       <= neg_in;
      mag_ff       <= mag_in;
      den_ff       <= den_in;
      num_ff       <= num_in;
      rem_ff       <= rem_in;
      quot_ff      <= quot_in;
      cnt_ff       <= cnt_in;
      out_dv_ff    <= out_dv_in;
      out_delta_ff <= out_delta_in;
      out_total_ff <= out_total_in;
      out_speed_ff <= out_speed_in;
   end

   // result ports
   assign rsp_empty         = !out_valid_ff;
   assign rsp_delta_valid   = out_dv_ff;
   assign rsp_delta         = out_delta_ff;
   assign rsp_total         = out_total_ff;
   assign rsp_speed_rpm_x10 = out_speed_ff;

endmodule

`default_nettype wire

[rtl/core/quadrature_counter_with_speed.sv]
// ----------------------------------------------------------------------------
// quadrature_counter_with_speed
// x4 quadrature decoder with pending/total counts and speed readout.
//
//   channel  ports                         handshake
//   input    req_pin_a .. req_window_ms    req_push / req_full
//   result   rsp_delta_valid .. rsp_speed  rsp_empty / rsp_pop
//   config   csr_wr_data                   csr_wr_en
//
// The front decodes and counts in the cycle an item is accepted.
// The back handles items in order: one without a speed read, or with zero elapsed
// time or zero counts per rev, skips the multiply and the 35 divider steps.
// Synchronous reset clears counts, queue and result; counts_per_rev goes to 1024.
// The front keeps accepting while the queue has room; a result waits in the
// output register until popped while the back works on the next item.
// ----------------------------------------------------------------------------
`default_nettype none

module quadrature_counter_with_speed #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_push,
   output logic                                  req_full,
   input  wire logic                             req_pin_a,
   input  wire logic                             req_pin_b,
   input  wire logic                             req_clear,
   input  wire logic                             req_take_delta,
   input  wire logic [qcs_pkg::ELAPSED_W-1:0]    req_window_ms,
   output logic                                  rsp_empty,
   input  wire logic                             rsp_pop,
   output logic                                  rsp_delta_valid,
   output logic signed [qcs_pkg::DELTA_W-1:0]    rsp_delta,
   output logic signed [qcs_pkg::TOTAL_W-1:0]    rsp_total,
   output logic signed [qcs_pkg::SPEED_W-1:0]    rsp_speed_rpm_x10,
   input  wire logic                             csr_wr_en,
   input  wire logic [qcs_pkg::CPR_W-1:0]        csr_wr_data
);
   import qcs_pkg::*;

   logic [CPR_W-1:0]    cpr_ff;
   logic                accept;
   logic                fifo_pop;
   qcs_item_type        front_item;
   qcs_item_type        head_item;
   qcs_fifo_status_type fifo_status;

   // counts per rev register
   always_ff @(posedge clock) begin
      if (reset) begin
         cpr_ff <= CPR_RESET;
      end else if (csr_wr_en) begin
         cpr_ff <= csr_wr_data;
      end
   end

   assign req_full = fifo_status.full;
   assign accept   = req_push && !fifo_status.full;

   qcs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .pin_a      (req_pin_a),
      .pin_b      (req_pin_b),
      .clear      (req_clear),
      .take_delta (req_take_delta),
      .window_ms  (req_window_ms),
      .item       (front_item)
   );

   qcs_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (accept),
      .wr_item (front_item),
      .rd_en   (fifo_pop),
      .rd_item (head_item),
      .status  (fifo_status)
   );

   qcs_back u_back (
      .clock             (clock),
      .reset             (reset),
      .counts_per_rev    (cpr_ff),
      .fifo_status       (fifo_status),
      .head_item         (head_item),
      .fifo_pop          (fifo_pop),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_delta_valid   (rsp_delta_valid),
      .rsp_delta         (rsp_delta),
      .rsp_total         (rsp_total),
      .rsp_speed_rpm_x10 (rsp_speed_rpm_x10)
   );

endmodule

`default_nettype wire

[rtl/core/qcs_checker.sv]
// ----------------------------------------------------------------------------
// qcs_checker
// Port-level checks on the result channel of the quadrature counter.
// ----------------------------------------------------------------------------
`default_nettype none

module qcs_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          rsp_empty,
   input wire logic                          rsp_pop,
   input wire logic                          rsp_delta_valid,
   input wire logic signed [15:0]            rsp_delta,
   input wire logic signed [31:0]            rsp_total,
   input wire logic signed [31:0]            rsp_speed_rpm_x10
);

   // no result right after reset
   assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result present after reset");

   // a waiting item keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_total)
                                    && $stable(rsp_speed_rpm_x10)))
      else $error("waiting result changed");

   // without a read, delta and speed are zero
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_delta_valid) |-> (rsp_delta == 16'sd0
                                            && rsp_speed_rpm_x10 == 32'sd0))
      else $error("speed or delta without a read");

   // speed sign follows delta sign
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_delta_valid) |->
         ((rsp_delta[15] && (rsp_speed_rpm_x10[31] || rsp_speed_rpm_x10 == 32'sd0))
          || (!rsp_delta[15] && !rsp_speed_rpm_x10[31])))
      else $error("speed sign differs from delta sign");

endmodule

bind quadrature_counter_with_speed qcs_checker u_qcs_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_empty         (rsp_empty),
   .rsp_pop           (rsp_pop),
   .rsp_delta_valid   (rsp_delta_valid),
   .rsp_delta         (rsp_delta),
   .rsp_total         (rsp_total),
   .rsp_speed_rpm_x10 (rsp_speed_rpm_x10)
);

`default_nettype wire

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the x4 quadrature counter with speed readout.
// Drives encoder pin items through the push/full side with random bursts,
// pops results with a changing stall pattern, and compares every result
// field against an in-bench decoder that tracks pins, pending and total
// counts and the counts-per-rev setting.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import qcs_pkg::*;

   localparam int CYCLE_LIMIT   = 400_000;
   localparam int SETTLE_CYCLES = 60;
   localparam int SPIN_STEPS    = 60;

   // quarter-turn codes: phase difference between two pin states
   localparam logic [1:0] QUARTER_FWD  = 2'd1;
   localparam logic [1:0] QUARTER_BACK = 2'd3;

   typedef enum logic [2:0] {
      POP_ALWAYS,
      POP_MOSTLY,
      POP_HALF,
      POP_RARE,
      POP_PERIODIC
   } pop_mode_type;

   typedef struct packed {
      logic                 pin_a;
      logic                 pin_b;
      logic                 clear;
      logic                 take_delta;
      logic [ELAPSED_W-1:0] window_ms;
   } pin_item_type;

   typedef struct packed {
      logic                      delta_valid;
      logic signed [DELTA_W-1:0] delta;
      logic signed [TOTAL_W-1:0] total;
      logic signed [SPEED_W-1:0] speed;
   } encoder_reading_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_push = 1'b0;
   logic                 req_full;
   logic                 req_pin_a = 1'b0;
   logic                 req_pin_b = 1'b0;
   logic                 req_clear = 1'b0;
   logic                 req_take_delta = 1'b0;
   logic [ELAPSED_W-1:0] req_window_ms = '0;
   logic                 rsp_empty;
   logic                 rsp_pop = 1'b0;
   logic                 rsp_delta_valid;
   logic signed [DELTA_W-1:0] rsp_delta;
   logic signed [TOTAL_W-1:0] rsp_total;
   logic signed [SPEED_W-1:0] rsp_speed_rpm_x10;
   logic                 csr_wr_en = 1'b0;
   logic [CPR_W-1:0]     csr_wr_data = '0;

   // stimulus and expected result stores
   pin_item_type        pin_items[$];
   encoder_reading_type readings_due[$];

   // decoder state mirrored in the bench
   logic [1:0]                prev_pin_state = 2'b00;
   logic signed [31:0]        pending_steps = '0;
   logic signed [31:0]        total_steps = '0;
   logic [CPR_W-1:0]          cpr_setting = CPR_RESET;

   // generator position on the quadrature cycle
   logic [1:0] gen_phase = 2'd0;

   int unsigned cycle_count = 0;
   int unsigned mismatches = 0;
   int unsigned results_checked = 0;
   int unsigned reads_checked = 0;
   int unsigned clears_sent = 0;
   int unsigned speed_clips = 0;
   int unsigned cpr_writes = 0;

   always #1 clock = ~clock;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   quadrature_counter_with_speed dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_pin_a         (req_pin_a),
      .req_pin_b         (req_pin_b),
      .req_clear         (req_clear),
      .req_take_delta    (req_take_delta),
      .req_window_ms     (req_window_ms),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_delta_valid   (rsp_delta_valid),
      .rsp_delta         (rsp_delta),
      .rsp_total         (rsp_total),
      .rsp_speed_rpm_x10 (rsp_speed_rpm_x10),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   // position of a pin state on the count-up cycle 00, 10, 11, 01
   function automatic logic [1:0] phase_of(input logic [1:0] ab);
      case (ab)
         2'b00:   return 2'd0;
         2'b10:   return 2'd1;
         2'b11:   return 2'd2;
         default: return 2'd3;
      endcase
   endfunction

   function automatic logic [1:0] pins_at(input logic [1:0] phase);
      case (phase)
         2'd0:    return 2'b00;
         2'd1:    return 2'b10;
         2'd2:    return 2'b11;
         default: return 2'b01;
      endcase
   endfunction

   // tenths of rpm, rounded half away from zero, clipped to 32 bits
   function automatic logic signed [SPEED_W-1:0] rpm_x10_of(
      input logic signed [DELTA_W-1:0] d, input logic [ELAPSED_W-1:0] el);
      logic [63:0] den;
      logic [63:0] mag;
      logic [63:0] quo;
      den = {48'd0, cpr_setting} * {48'd0, el};
      if (den == 0)
         return '0;
      mag = d[DELTA_W-1] ? (64'd65536 - {48'd0, d}) : {48'd0, d};
      quo = (mag * 64'd600000 + den / 2) / den;
      if (!d[DELTA_W-1])
         return (quo > 64'h7FFF_FFFF) ? SPEED_MAX : quo[31:0];
      if (quo > 64'h8000_0000)
         quo = 64'h8000_0000;
      return -quo[31:0];
   endfunction

   // advance the mirrored decoder by one accepted item
   function automatic encoder_reading_type decode_item(input pin_item_type it);
      encoder_reading_type r;
      logic [1:0]          cur;
      logic [1:0]          turn;
      cur = {it.pin_a, it.pin_b};
      r = '0;
      if (it.clear) begin
         pending_steps = '0;
         total_steps = '0;
      end else begin
         turn = phase_of(cur) - phase_of(prev_pin_state);
         if (turn == QUARTER_FWD) begin
            pending_steps = pending_steps + 1;
            total_steps = total_steps + 1;
         end else if (turn == QUARTER_BACK) begin
            pending_steps = pending_steps - 1;
            total_steps = total_steps - 1;
         end
      end
      prev_pin_state = cur;
      r.delta_valid = it.take_delta;
      r.total = total_steps;
      if (it.take_delta) begin
         if (pending_steps > 32767)
            r.delta = DELTA_MAX;
         else if (pending_steps < -32768)
            r.delta = DELTA_MIN;
         else
            r.delta = pending_steps[DELTA_W-1:0];
         pending_steps = '0;
         r.speed = rpm_x10_of(r.delta, it.window_ms);
      end
      return r;
   endfunction

   function automatic void check_field(input string name,
      input logic signed [31:0] want, input logic signed [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   task automatic queue_item(input logic a, input logic b, input logic clr,
      input logic take, input logic [ELAPSED_W-1:0] el);
      pin_item_type it;
      it.pin_a = a;
      it.pin_b = b;
      it.clear = clr;
      it.take_delta = take;
      it.window_ms = el;
      pin_items.push_back(it);
      gen_phase = phase_of({a, b});
   endtask

   // legal quarter turns in one direction, no reads
   task automatic walk_steps(input int n, input bit forward);
      logic [1:0] ab;
      for (int i = 0; i < n; i++) begin
         ab = pins_at(forward ? gen_phase + 2'd1 : gen_phase - 2'd1);
         queue_item(ab[1], ab[0], 1'b0, 1'b0, 16'($urandom));
      end
   endtask

   // read at the current pins, no movement
   task automatic queue_read(input logic [ELAPSED_W-1:0] el);
      logic [1:0] ab;
      ab = pins_at(gen_phase);
      queue_item(ab[1], ab[0], 1'b0, 1'b1, el);
   endtask

   // mostly legal walks with a forward bias, some jumps, clears and reads
   task automatic queue_random(input int n);
      int         pick;
      int         el_pick;
      logic       take;
      logic [1:0] ab;
      logic [ELAPSED_W-1:0] el;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 99);
         take = ($urandom_range(0, 99) < 15);
         el_pick = $urandom_range(0, 9);
         if (el_pick == 0)
            el = '0;
         else if (el_pick == 1)
            el = '1;
         else if (el_pick < 6)
            el = 16'($urandom_range(1, 1000));
         else
            el = 16'($urandom);
         if (pick < 3) begin
            ab = 2'($urandom);
            queue_item(ab[1], ab[0], 1'b1, take, el);
         end else if (pick < 6) begin
            ab = pins_at(gen_phase) ^ 2'b11;
            queue_item(ab[1], ab[0], 1'b0, take, el);
         end else if (pick < 8) begin
            ab = 2'($urandom);
            queue_item(ab[1], ab[0], 1'b0, take, el);
         end else begin
            if (pick < 55)
               ab = pins_at(gen_phase + 2'd1);
            else if (pick < 88)
               ab = pins_at(gen_phase - 2'd1);
            else
               ab = pins_at(gen_phase);
            queue_item(ab[1], ab[0], 1'b0, take, el);
         end
      end
   endtask

   // wait until every item is in and every result is out
   task automatic drain();
      do
         @(negedge clock);
      while (pin_items.size() != 0 || req_push || readings_due.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_cpr(input logic [CPR_W-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      cpr_setting = value;
      cpr_writes++;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // item driver: bursts of random length with random gaps
   always @(posedge clock) begin : item_driver
      pin_item_type next_item;
      pin_item_type sent;
      int           burst_left;
      int           idle_left;
      if (req_push && !req_full) begin
         sent = {req_pin_a, req_pin_b, req_clear, req_take_delta, req_window_ms};
         if (sent.clear)
            clears_sent++;
         readings_due.push_back(decode_item(sent));
      end
      if (reset) begin
         req_push <= 1'b0;
         burst_left = 0;
         idle_left = 0;
      end else if (req_push && req_full) begin
         // hold the item until it is taken
      end else if (idle_left > 0) begin
         idle_left--;
         req_push <= 1'b0;
      end else if (pin_items.size() != 0) begin
         next_item = pin_items.pop_front();
         req_pin_a <= next_item.pin_a;
         req_pin_b <= next_item.pin_b;
         req_clear <= next_item.clear;
         req_take_delta <= next_item.take_delta;
         req_window_ms <= next_item.window_ms;
         req_push <= 1'b1;
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            burst_left = $urandom_range(1, 24);
            idle_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
         end
      end else begin
         req_push <= 1'b0;
      end
   end

   // result monitor with a randomly re-picked stall pattern
   always @(posedge clock) begin : result_monitor
      encoder_reading_type want;
      pop_mode_type        mode;
      if (rsp_pop && !rsp_empty) begin
         results_checked++;
         if (readings_due.size() == 0) begin
            $display("%0t: result with nothing expected, total %0d", $time, rsp_total);
            mismatches++;
         end else begin
            want = readings_due.pop_front();
            if (want.delta_valid)
               reads_checked++;
            if (want.delta_valid && (want.speed == SPEED_MAX || want.speed == 32'sh8000_0000))
               speed_clips++;
            check_field("delta_valid", 32'(want.delta_valid), 32'(rsp_delta_valid));
            check_field("delta", 32'(want.delta), 32'(rsp_delta));
            check_field("total", want.total, rsp_total);
            check_field("speed_rpm_x10", want.speed, rsp_speed_rpm_x10);
         end
      end
      if (cycle_count % 48 == 0)
         mode = pop_mode_type'($urandom_range(0, 4));
      if (reset)
         rsp_pop <= 1'b0;
      else
         case (mode)
            POP_ALWAYS:   rsp_pop <= 1'b1;
            POP_MOSTLY:   rsp_pop <= ($urandom_range(0, 3) != 0);
            POP_HALF:     rsp_pop <= 1'($urandom_range(0, 1));
            POP_RARE:     rsp_pop <= ($urandom_range(0, 4) == 0);
            default:      rsp_pop <= cycle_count[2];
         endcase
   end

   // run limit
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d results still due",
               cycle_count, readings_due.size());
      $display("end of test: mismatches");
      $finish;
   end

   // stimulus phases, one counts-per-rev setting each
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // directed: clear with read, reads at zero and full elapsed,
      // illegal jumps, step in the read item, clear hiding a step
      write_cpr(CPR_RESET);
      @(negedge clock);
      queue_item(1'b0, 1'b0, 1'b1, 1'b1, 16'd100);
      walk_steps(4, 1'b1);
      queue_read(16'd0);
      walk_steps(2, 1'b0);
      queue_read(16'hFFFF);
      queue_item(1'b0, 1'b0, 1'b0, 1'b0, 16'h5A5A);
      queue_item(1'b1, 1'b1, 1'b0, 1'b1, 16'd1);
      queue_item(1'b0, 1'b1, 1'b0, 1'b1, 16'd3);
      queue_item(1'b1, 1'b0, 1'b1, 1'b0, 16'hA5A5);
      queue_item(1'b1, 1'b1, 1'b0, 1'b1, 16'd7);
      walk_steps(3, 1'b1);
      queue_item(1'b1, 1'b1, 1'b1, 1'b1, 16'hFFFF);
      drain();

      // spins both ways at one count per rev, short and full elapsed reads
      write_cpr(16'd1);
      @(negedge clock);
      walk_steps(SPIN_STEPS, 1'b1);
      queue_read(16'd1);
      walk_steps(SPIN_STEPS, 1'b0);
      queue_read(16'd1);
      walk_steps(5, 1'b1);
      queue_read(16'hFFFF);
      drain();

      // zero counts per rev gives zero speed
      write_cpr(16'd0);
      @(negedge clock);
      walk_steps(10, 1'b1);
      queue_read(16'd10);
      queue_random(100);
      drain();

      write_cpr(16'hFFFF);
      @(negedge clock);
      queue_random(400);
      drain();

      repeat (3) begin
         write_cpr(16'($urandom_range(1, 65535)));
         @(negedge clock);
         queue_random(250);
         drain();
      end

      write_cpr(16'd1);
      @(negedge clock);
      queue_random(200);
      drain();

      $display("checked %0d results, %0d with a count read, %0d clears sent",
               results_checked, reads_checked, clears_sent);
      $display("%0d clipped speeds over %0d counts-per-rev settings",
               speed_clips, cpr_writes);
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

[sim.f]
rtl/core/qcs_pkg.sv
rtl/core/qcs_front.sv
rtl/core/qcs_fifo.sv
rtl/core/qcs_back.sv
rtl/core/quadrature_counter_with_speed.sv
rtl/core/qcs_checker.sv
bench/testbench.sv
